// ===== sv/lcpr_pkg.sv =====
// Package for the local clock page replacement unit.
// Holds defaults, field widths, mode codes and the controller/datapath structs.
// No dependencies.
package lcpr_pkg;

    // Default sizing
    localparam int FRAMES_DEF   = 64;
    localparam int PID_BITS_DEF = 8;

    // Fixed port field widths
    localparam int FRAME_W = 6;
    localparam int PID_W   = 8;

    // Input transaction modes
    typedef enum logic [1:0] {
        MODE_REF    = 2'd0,
        MODE_LOAD   = 2'd1,
        MODE_VICTIM = 2'd2
    } t_mode;

    // Commands from controller to datapath
    typedef struct packed {
        logic clear;       // write one zeroed entry of the clearing pass
        logic accept;      // latch input fields, read entry at frame index
        logic upd;         // write back a reference or a load
        logic scan_start;  // read entry at the hand, reset sweep counters
        logic scan_step;   // evaluate one frame, prefetch the next
        logic push;        // move the search result into the output register
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic clr_last;    // clearing pass is at the last entry
        logic hit;         // frame under evaluation is the victim
        logic scan_end;    // last step of the last pass
        logic out_free;    // output register can take a result this cycle
    } t_dp_stat;

endpackage

// ===== sv/lcpr_ctrl.sv =====
// Controller state machine of the local clock page replacement unit.
// Sequences the clearing pass, updates and victim searches.
// Depends on lcpr_pkg.
module lcpr_ctrl import lcpr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic [1:0] i_mode,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_in_stall
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_UPD,
        S_START,
        S_SCAN,
        S_PUSH
    } t_state;

    t_state r_state;

    // Take input only when idle
    assign o_in_stall = (r_state != S_IDLE);

    // Decode commands from state
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_CLEAR: o_cmd.clear      = 1'b1;
            S_IDLE:  o_cmd.accept     = i_in_valid;
            S_UPD:   o_cmd.upd        = 1'b1;
            S_START: o_cmd.scan_start = 1'b1;
            S_SCAN:  o_cmd.scan_step  = 1'b1;
            S_PUSH:  o_cmd.push       = i_stat.out_free;
        endcase
    end

    // Advance state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    if (i_stat.clr_last) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        unique case (i_mode)
                            MODE_REF, MODE_LOAD: r_state <= S_UPD;
                            MODE_VICTIM:         r_state <= S_START;
                            default:             r_state <= S_IDLE;
                        endcase
                    end
                end
                S_UPD:   r_state <= S_IDLE;
                S_START: r_state <= S_SCAN;
                S_SCAN: begin
                    if (i_stat.hit || i_stat.scan_end) r_state <= S_PUSH;
                end
                S_PUSH: begin
                    if (i_stat.out_free) r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== sv/lcpr_dp.sv =====
// Datapath of the local clock page replacement unit: frame table memory,
// clock hand, sweep counters, algorithm register and output register.
// Depends on lcpr_pkg.
module lcpr_dp import lcpr_pkg::*; #(
    parameter int FRAMES   = FRAMES_DEF,
    parameter int PID_BITS = PID_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_stat           o_stat,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata,
    input  logic [1:0]         i_mode,
    input  logic [FRAME_W-1:0] i_frame_index,
    input  logic [PID_W-1:0]   i_process_id,
    input  logic               i_is_write,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output logic [FRAME_W-1:0] o_victim_frame,
    output logic               o_victim_found
);

    localparam int AW    = $clog2(FRAMES);
    localparam int EW    = PID_BITS + 3;
    localparam int V_BIT = PID_BITS + 2;
    localparam int U_BIT = PID_BITS + 1;
    localparam int M_BIT = PID_BITS;
    localparam int FXW   = (AW > FRAME_W) ? AW : FRAME_W;
    localparam int PXW   = (PID_BITS > PID_W) ? PID_BITS : PID_W;
    localparam logic [AW-1:0] LAST = AW'(FRAMES - 1);

    // Frame table: {valid, use, modified, owner}
    logic [EW-1:0] r_mem [FRAMES];
    logic [EW-1:0] r_rd;

    logic [AW-1:0]       r_hand;
    logic [AW-1:0]       r_eval;
    logic [AW-1:0]       r_step;
    logic [1:0]          r_pass;
    logic [AW-1:0]       r_clr;
    logic                r_alg;
    logic [AW-1:0]       r_addr;
    logic                r_in_range;
    logic                r_is_load;
    logic [PID_BITS-1:0] r_pid;
    logic                r_wr;
    logic                r_res_found;
    logic [FRAME_W-1:0]  r_res_frame;
    logic                r_out_valid;
    logic [FRAME_W-1:0]  r_out_frame;
    logic                r_out_found;

    logic [FXW-1:0]      in_fx;
    logic [AW-1:0]       in_addr;
    logic [PXW-1:0]      in_px;
    logic [FXW-1:0]      eval_x;
    logic [AW-1:0]       hand_inc;
    logic                owned;
    logic                clearing;
    logic                hit;
    logic                scan_end;
    logic                stop;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [EW-1:0]       mem_wdata;
    logic [AW-1:0]       mem_raddr;

    // Fit port fields to the table's address and owner widths
    assign in_fx   = FXW'(i_frame_index);
    assign in_addr = in_fx[AW-1:0];
    assign in_px   = PXW'(i_process_id);
    assign eval_x  = FXW'(r_eval);

    assign hand_inc = (r_hand == LAST) ? '0 : r_hand + 1'b1;

    // Evaluate the frame whose entry was read last cycle
    assign owned    = r_rd[V_BIT] && (r_rd[PID_BITS-1:0] == r_pid);
    assign clearing = !r_alg || r_pass[0];
    assign hit      = owned && !r_rd[U_BIT] && (!r_alg || (r_rd[M_BIT] == r_pass[0]));
    assign scan_end = (r_step == LAST) && (r_alg ? (r_pass == 2'd3) : (r_pass == 2'd1));
    assign stop     = hit || scan_end;

    assign o_stat.clr_last = (r_clr == LAST);
    assign o_stat.hit      = hit;
    assign o_stat.scan_end = scan_end;
    assign o_stat.out_free = !r_out_valid || !i_out_stall;

    // Select memory write
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_eval;
        mem_wdata = r_rd;
        priority if (i_cmd.clear) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr;
            mem_wdata = '0;
        end else if (i_cmd.upd) begin
            mem_we    = r_in_range;
            mem_waddr = r_addr;
            if (r_is_load) begin
                mem_wdata = {1'b1, 1'b1, r_wr, r_pid};
            end else begin
                mem_wdata = {r_rd[V_BIT], 1'b1, r_rd[M_BIT] | r_wr, r_rd[PID_BITS-1:0]};
            end
        end else if (i_cmd.scan_step) begin
            // second chance: drop the use bit of an owned frame passed over on a clearing pass
            mem_we    = owned && clearing && r_rd[U_BIT];
            mem_waddr = r_eval;
            mem_wdata = r_rd & ~(EW'(1) << U_BIT);
        end
    end

    // Select memory read address
    always_comb begin
        priority if (i_cmd.accept) begin
            mem_raddr = in_addr;
        end else begin
            mem_raddr = r_hand;
        end
    end

    // Frame table memory with registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd <= r_mem[mem_raddr];
    end

    // Latch input transaction fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_addr     <= in_addr;
            r_in_range <= (32'(i_frame_index) < FRAMES);
            r_is_load  <= (i_mode == MODE_LOAD);
            r_pid      <= in_px[PID_BITS-1:0];
            r_wr       <= i_is_write;
        end
    end

    // Hold clearing counter, hand and algorithm register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr  <= '0;
            r_hand <= '0;
            r_alg  <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cfg_we) begin
                r_alg <= i_cfg_wdata;
            end
            if (i_cmd.scan_start || (i_cmd.scan_step && !stop)) begin
                r_hand <= hand_inc;
            end
        end
    end

    // Track frame under evaluation and sweep position; capture the result
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_eval <= r_hand;
            r_step <= '0;
            r_pass <= 2'd0;
        end else if (i_cmd.scan_step) begin
            r_eval <= r_hand;
            if (r_step == LAST) begin
                r_step <= '0;
                r_pass <= r_pass + 2'd1;
            end else begin
                r_step <= r_step + 1'b1;
            end
            if (hit) begin
                r_res_found <= 1'b1;
                r_res_frame <= eval_x[FRAME_W-1:0];
            end else if (scan_end) begin
                r_res_found <= 1'b0;
                r_res_frame <= '0;
            end
        end
    end

    // Output register: load on push, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out_frame <= r_res_frame;
            r_out_found <= r_res_found;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_victim_frame = r_out_frame;
    assign o_victim_found = r_out_found;

endmodule

// ===== sv/local_clock_page_replacement_unit.sv =====
// Local clock page replacement unit. After reset the frame table is cleared
// in one pass over its FRAMES entries, during which no input transaction
// is taken. A reference or a load reads the table entry, then writes it
// back. A victim request runs a search in which the hand visits frames one
// per cycle through the single-port table read: at most 2*FRAMES frames in
// plain clock mode and 4*FRAMES in enhanced mode. The result leaves through
// an output register; the next transaction is taken while that result waits
// to be taken.
// Depends on lcpr_pkg, lcpr_ctrl and lcpr_dp.
module local_clock_page_replacement_unit import lcpr_pkg::*; #(
    parameter int FRAMES   = FRAMES_DEF,
    parameter int PID_BITS = PID_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_mode,
    input  logic [FRAME_W-1:0] i_frame_index,
    input  logic [PID_W-1:0]   i_process_id,
    input  logic               i_is_write,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [FRAME_W-1:0] o_victim_frame,
    output logic               o_victim_found
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    lcpr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_mode),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    lcpr_dp #(
        .FRAMES   (FRAMES),
        .PID_BITS (PID_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_mode         (i_mode),
        .i_frame_index  (i_frame_index),
        .i_process_id   (i_process_id),
        .i_is_write     (i_is_write),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_victim_frame (o_victim_frame),
        .o_victim_found (o_victim_found)
    );

`ifndef NO_ASSERTIONS
    // A result appears only after a transaction was being worked on
    a_out_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without a victim search in progress");

    // A failed search reports frame zero
    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_victim_found) |-> (o_victim_frame == '0))
        else $error("not-found result carries a nonzero frame");

    // A victim request holds off the next transaction
    a_victim_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_mode == MODE_VICTIM)) |=> o_in_stall)
        else $error("input taken during a victim search");
`endif

endmodule

// ===== sim/tb_local_clock_page_replacement_unit.sv =====
// Self-checking testbench for local_clock_page_replacement_unit.
// Mirrors the frame table and clock hand to predict each victim result.
// Depends on lcpr_pkg and the unit's RTL.
module tb_local_clock_page_replacement_unit import lcpr_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          FRAMES        = FRAMES_DEF;
    localparam logic [1:0]  MODE_UNUSED   = 2'd3;
    localparam logic        ALG_PLAIN     = 1'b0;
    localparam logic        ALG_ENHANCED  = 1'b1;
    localparam int          SETTLE_CYCLES = 270;
    localparam int          DRAIN_LIMIT   = 20000;
    localparam int          IDLE_PERCENT  = 17;
    localparam int          HOLD_CYCLES   = 800;

    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic               found;
    } t_victim_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic               i_cfg_wdata;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [1:0]         i_mode;
    logic [FRAME_W-1:0] i_frame_index;
    logic [PID_W-1:0]   i_process_id;
    logic               i_is_write;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [FRAME_W-1:0] o_victim_frame;
    logic               o_victim_found;

    // Mirror of the frame table
    logic [PID_W-1:0]   frame_owner [FRAMES];
    logic               frame_live  [FRAMES];
    logic               use_bits    [FRAMES];
    logic               mod_bits    [FRAMES];
    logic [FRAME_W-1:0] clock_hand;
    logic               algorithm_sel;

    t_victim_result     expected_victims [$];
    int                 error_count;
    int                 hold_requests;
    int                 hold_seen   = 0;
    int                 hold_cycles = 0;
    bit                 idle_enable;

    local_clock_page_replacement_unit DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_mode         (i_mode),
        .i_frame_index  (i_frame_index),
        .i_process_id   (i_process_id),
        .i_is_write     (i_is_write),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_victim_frame (o_victim_frame),
        .o_victim_found (o_victim_found)
    );

    always #6 i_clk = ~i_clk;

    // Hard stop in case the unit hangs
    initial begin
        #40_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= 10) begin
            $display("ERROR at %0t: %s", $time, msg);
        end
    endtask

    function automatic void advance_hand();
        clock_hand = (clock_hand == FRAMES - 1) ? '0 : clock_hand + 1'b1;
    endfunction

    function automatic logic owned_by(input logic [FRAME_W-1:0] f, input logic [PID_W-1:0] pid);
        return frame_live[f] && (frame_owner[f] == pid);
    endfunction

    // Second chance: clear use bits until an owned frame with use = 0 turns up
    function automatic logic search_plain_clock(input logic [PID_W-1:0] pid,
                                                output logic [FRAME_W-1:0] victim);
        logic               hit;
        logic [FRAME_W-1:0] f;
        hit    = 1'b0;
        victim = '0;
        for (int step = 0; step < 2 * FRAMES && !hit; step++) begin
            f = clock_hand;
            advance_hand();
            if (owned_by(f, pid)) begin
                if (!use_bits[f]) begin
                    hit    = 1'b1;
                    victim = f;
                end else begin
                    use_bits[f] = 1'b0;
                end
            end
        end
        return hit;
    endfunction

    // Four passes: (0,0), then (0,1) while clearing use bits, twice over
    function automatic logic search_enhanced_clock(input logic [PID_W-1:0] pid,
                                                   output logic [FRAME_W-1:0] victim);
        logic               hit;
        logic               clearing;
        logic [FRAME_W-1:0] f;
        hit    = 1'b0;
        victim = '0;
        for (int pass = 0; pass < 4 && !hit; pass++) begin
            clearing = (pass % 2) == 1;
            for (int step = 0; step < FRAMES && !hit; step++) begin
                f = clock_hand;
                advance_hand();
                if (owned_by(f, pid)) begin
                    if (!use_bits[f] && mod_bits[f] == clearing) begin
                        hit    = 1'b1;
                        victim = f;
                    end else if (clearing) begin
                        use_bits[f] = 1'b0;
                    end
                end
            end
        end
        return hit;
    endfunction

    // Apply one transaction to the mirror; return 1 when it yields a victim result
    function automatic logic page_table_step(input logic [1:0] mode,
                                             input logic [FRAME_W-1:0] frame,
                                             input logic [PID_W-1:0] pid,
                                             input logic wr,
                                             output t_victim_result res);
        logic               has_result;
        logic               hit;
        logic [FRAME_W-1:0] victim;
        has_result = 1'b0;
        res        = '0;
        case (mode)
            MODE_REF: begin
                use_bits[frame] = 1'b1;
                if (wr) begin
                    mod_bits[frame] = 1'b1;
                end
            end
            MODE_LOAD: begin
                frame_owner[frame] = pid;
                frame_live[frame]  = 1'b1;
                use_bits[frame]    = 1'b1;
                mod_bits[frame]    = wr;
            end
            MODE_VICTIM: begin
                if (algorithm_sel == ALG_ENHANCED) begin
                    hit = search_enhanced_clock(pid, victim);
                end else begin
                    hit = search_plain_clock(pid, victim);
                end
                res.frame  = hit ? victim : '0;
                res.found  = hit;
                has_result = 1'b1;
            end
            default: ;
        endcase
        return has_result;
    endfunction

    // Offer one transaction, hold it until accepted, then update the mirror
    task automatic send_item(input logic [1:0] mode, input logic [FRAME_W-1:0] frame,
                             input logic [PID_W-1:0] pid, input logic wr);
        t_victim_result res;
        @(negedge i_clk);
        while (idle_enable && $urandom_range(99) < IDLE_PERCENT) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_mode        <= mode;
        i_frame_index <= frame;
        i_process_id  <= pid;
        i_is_write    <= wr;
        do @(posedge i_clk); while (o_in_stall);
        if (page_table_step(mode, frame, pid, wr, res)) begin
            expected_victims.push_back(res);
        end
    endtask

    // Drop valid, wait for every pending result, then let the unit settle
    task automatic wait_idle();
        int guard;
        guard = 0;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_victims.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_algorithm(input logic alg);
        wait_idle();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= alg;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        algorithm_sel = alg;
    endtask

    // Mostly a small pool of owners so searches hit, some fully random ids
    task automatic send_random_item();
        int unsigned        pick;
        logic [1:0]         mode;
        logic [PID_W-1:0]   pid;
        pick = $urandom_range(99);
        if (pick < 35)      mode = MODE_LOAD;
        else if (pick < 70) mode = MODE_REF;
        else if (pick < 96) mode = MODE_VICTIM;
        else                mode = MODE_UNUSED;
        if ($urandom_range(9) < 8) begin
            case ($urandom_range(3))
                0:       pid = 8'h00;
                1:       pid = 8'h5A;
                2:       pid = 8'hA5;
                default: pid = 8'hFF;
            endcase
        end else begin
            pid = PID_W'($urandom_range(255));
        end
        send_item(mode, FRAME_W'($urandom_range(FRAMES - 1)), pid, 1'($urandom_range(1)));
    endtask

    // Drive the output stall: long hold-off when requested, else random
    always @(negedge i_clk) begin
        if (hold_requests != hold_seen) begin
            hold_seen   <= hold_requests;
            hold_cycles <= HOLD_CYCLES - 1;
            i_out_stall <= 1'b1;
        end else if (hold_cycles > 0) begin
            i_out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else if (idle_enable) begin
            i_out_stall <= ($urandom_range(99) < IDLE_PERCENT);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin : check_result
        t_victim_result exp_res;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_victims.size() == 0) begin
                report_error($sformatf("unexpected result frame=%0d found=%0b",
                                       o_victim_frame, o_victim_found));
            end else begin
                exp_res = expected_victims.pop_front();
                if (o_victim_frame !== exp_res.frame || o_victim_found !== exp_res.found) begin
                    report_error($sformatf("expected frame=%0d found=%0b, got frame=%0d found=%0b",
                                           exp_res.frame, exp_res.found,
                                           o_victim_frame, o_victim_found));
                end
            end
        end
    end

    // Empty table, unused frame, extreme ids and frames, mode 3, plain clock
    task automatic test_directed_plain();
        set_algorithm(ALG_PLAIN);
        send_item(MODE_VICTIM, 6'd0, 8'h00, 1'b0);
        send_item(MODE_REF, 6'd5, 8'h00, 1'b1);
        send_item(MODE_LOAD, 6'd0, 8'h00, 1'b0);
        send_item(MODE_LOAD, 6'd63, 8'hFF, 1'b1);
        send_item(MODE_VICTIM, 6'd63, 8'h00, 1'b1);
        send_item(MODE_VICTIM, 6'd0, 8'hFF, 1'b0);
        send_item(MODE_UNUSED, 6'd63, 8'hFF, 1'b1);
        send_item(MODE_LOAD, 6'd5, 8'h00, 1'b0);
        send_item(MODE_REF, 6'd0, 8'h00, 1'b1);
        send_item(MODE_VICTIM, 6'd0, 8'h00, 1'b0);
        send_item(MODE_VICTIM, 6'd0, 8'h00, 1'b0);
        send_item(MODE_VICTIM, 6'd0, 8'h80, 1'b0);
    endtask

    // Mix of (use, modified) pairs for one owner to walk all four passes
    task automatic test_directed_enhanced();
        set_algorithm(ALG_ENHANCED);
        send_item(MODE_LOAD, 6'd10, 8'h03, 1'b0);
        send_item(MODE_LOAD, 6'd20, 8'h03, 1'b1);
        send_item(MODE_LOAD, 6'd30, 8'h03, 1'b0);
        send_item(MODE_REF, 6'd30, 8'h03, 1'b1);
        send_item(MODE_VICTIM, 6'd0, 8'h03, 1'b0);
        send_item(MODE_VICTIM, 6'd0, 8'h03, 1'b0);
        send_item(MODE_VICTIM, 6'd0, 8'h03, 1'b0);
        send_item(MODE_VICTIM, 6'd0, 8'h03, 1'b0);
        send_item(MODE_REF, 6'd63, 8'h00, 1'b0);
        send_item(MODE_VICTIM, 6'd0, 8'hFF, 1'b0);
        send_item(MODE_VICTIM, 6'd0, 8'h01, 1'b0);
    endtask

    // Random traffic, pausing halfway until all results are back
    task automatic test_random(input logic alg, input int count);
        set_algorithm(alg);
        for (int n = 0; n < count; n++) begin
            if (n == count / 2) begin
                wait_idle();
            end
            send_random_item();
        end
    endtask

    // Back-to-back traffic with no idling on either side
    task automatic test_burst_no_idle(input int count);
        set_algorithm(ALG_PLAIN);
        idle_enable = 1'b0;
        for (int n = 0; n < count; n++) begin
            send_random_item();
        end
        wait_idle();
        idle_enable = 1'b1;
    endtask

    // Hold off the receiver so results back up and the input stalls
    task automatic test_output_holdoff();
        set_algorithm(ALG_ENHANCED);
        hold_requests++;
        send_item(MODE_LOAD, 6'd1, 8'h5A, 1'b1);
        send_item(MODE_LOAD, 6'd2, 8'h5A, 1'b0);
        send_item(MODE_LOAD, 6'd40, 8'hA5, 1'b1);
        for (int n = 0; n < 12; n++) begin
            send_item(MODE_VICTIM, FRAME_W'(n), (n % 2 == 0) ? 8'h5A : 8'hA5, 1'b0);
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = 1'b0;
        i_in_valid    = 1'b0;
        i_mode        = MODE_REF;
        i_frame_index = '0;
        i_process_id  = '0;
        i_is_write    = 1'b0;
        error_count   = 0;
        hold_requests = 0;
        idle_enable   = 1'b1;
        clock_hand    = '0;
        algorithm_sel = ALG_PLAIN;
        for (int f = 0; f < FRAMES; f++) begin
            frame_owner[f] = '0;
            frame_live[f]  = 1'b0;
            use_bits[f]    = 1'b0;
            mod_bits[f]    = 1'b0;
        end

        // Hold reset, release on a falling edge
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_plain();
        test_directed_enhanced();
        test_random(ALG_PLAIN, 500);
        test_random(ALG_ENHANCED, 500);
        test_burst_no_idle(300);
        test_output_holdoff();
        test_random(ALG_ENHANCED, 400);
        test_random(ALG_PLAIN, 300);
        wait_idle();

        if (expected_victims.size() != 0) begin
            report_error($sformatf("%0d expected results never arrived",
                                   expected_victims.size()));
        end
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/lcpr_pkg.sv
sv/lcpr_ctrl.sv
sv/lcpr_dp.sv
sv/local_clock_page_replacement_unit.sv
sim/tb_local_clock_page_replacement_unit.sv
